@@ src/cnap_pkg.sv @@
// cnap_pkg: types, constants and helper functions for the cpio newc archive parser.
// No dependencies; imported by the parser top level and its checker.
package cnap_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_NAME   = 2'd1,
        PH_SKIP   = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_FILE    = 2'd1;
    localparam logic [1:0] KIND_TRAILER = 2'd2;
    localparam logic [1:0] KIND_BADMAG  = 2'd3;

    localparam logic [6:0] HDR_LAST     = 7'd109;
    localparam logic [6:0] MAGIC_LEN    = 7'd6;
    localparam logic [6:0] FSIZE_FIRST  = 7'd54;
    localparam logic [6:0] FSIZE_LAST   = 7'd61;
    localparam logic [6:0] NSIZE_FIRST  = 7'd94;
    localparam logic [6:0] NSIZE_LAST   = 7'd101;
    localparam logic [31:0] TRAILER_LAST = 32'd10;

    typedef struct packed {
        logic [7:0] archive_byte;
        logic       restart;
    } arc_item_t;

    typedef struct packed {
        logic [7:0]  name_byte;
        logic        name_byte_kept;
        logic [1:0]  record_kind;
        logic [31:0] data_offset;
        logic [31:0] file_size;
        logic [31:0] name_size;
    } rec_item_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'h30 && c <= 8'h39)
                d = c - 8'h30;
            else if (c >= 8'h41 && c <= 8'h46)
                d = c - 8'h37;
            hex_value = d[3:0];
        end
    endfunction

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        begin
            unique case (idx)
                3'd0:    magic_char = 8'h30;
                3'd1:    magic_char = 8'h37;
                3'd2:    magic_char = 8'h30;
                3'd3:    magic_char = 8'h37;
                3'd4:    magic_char = 8'h30;
                3'd5:    magic_char = 8'h31;
                default: magic_char = 8'h00;
            endcase
        end
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        begin
            unique case (idx)
                4'd0:    trailer_char = 8'h54;
                4'd1:    trailer_char = 8'h52;
                4'd2:    trailer_char = 8'h41;
                4'd3:    trailer_char = 8'h49;
                4'd4:    trailer_char = 8'h4C;
                4'd5:    trailer_char = 8'h45;
                4'd6:    trailer_char = 8'h52;
                4'd7:    trailer_char = 8'h21;
                4'd8:    trailer_char = 8'h21;
                4'd9:    trailer_char = 8'h21;
                default: trailer_char = 8'h00;
            endcase
        end
    endfunction

endpackage

@@ src/cpio_newc_archive_parser_top.sv @@
// A result is registered and shown in the cycle after its archive byte is accepted.
// Throughput: one archive byte per cycle; the result register drains while the
// next byte is taken, so arc_stall rises only while a held result is stalled.
// Reset: rst_n (async, active low) clears parse state to header phase, offset 0.
// cpio newc archive parser top level; depends on cnap_pkg.
// Header bytes, name bytes and skip bytes are handled in one registered pass.
module cpio_newc_archive_parser_top #(
    parameter int NAME_KEEP_LIMIT = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                arc_valid,
    output logic                arc_stall,
    input  cnap_pkg::arc_item_t arc_item,
    output logic                rec_valid,
    input  logic                rec_stall,
    output cnap_pkg::rec_item_t rec_item
);
    import cnap_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] offset_reg, offset_next;
    logic [6:0]  hidx_reg, hidx_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] nsize_reg, nsize_next;
    logic [31:0] nidx_reg, nidx_next;
    logic        tmatch_reg, tmatch_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] size_pad_reg, size_pad_next;
    logic [31:0] name_last_reg, name_last_next;
    logic        rec_valid_reg;
    rec_item_t   rec_item_reg;

    logic        accept;
    logic        produce;
    rec_item_t   res;

    logic [7:0]  b;
    logic        rs;
    logic [31:0] cur;
    phase_t      ph_e;
    logic [6:0]  hidx_e;
    logic [31:0] size_e, nsize_e, nidx_e, skip_e;
    logic        tm_e, tm_new;
    logic [3:0]  hv;
    logic [31:0] acc_size, acc_nsize, skip_calc, skip_dec;

    assign arc_stall = rec_valid_reg & rec_stall;
    assign accept    = arc_valid & ~arc_stall;
    assign rec_valid = rec_valid_reg;
    assign rec_item  = rec_item_reg;

    always_comb
    begin
        b      = arc_item.archive_byte;
        rs     = arc_item.restart;
        cur    = rs ? 32'd0 : offset_reg;
        ph_e   = rs ? PH_HEADER : phase_reg;
        hidx_e = rs ? 7'd0 : hidx_reg;
        size_e = rs ? 32'd0 : size_reg;
        nsize_e = rs ? 32'd0 : nsize_reg;
        nidx_e = rs ? 32'd0 : nidx_reg;
        tm_e   = rs ? 1'b1 : tmatch_reg;
        skip_e = rs ? 32'd0 : skip_reg;
        hv     = hex_value(b);
        acc_size  = {size_e[27:0], hv};
        acc_nsize = {nsize_e[27:0], hv};
        skip_calc = size_pad_reg + {30'd0, 2'd3 - cur[1:0]};
        skip_dec  = skip_e - 32'd1;
        tm_new    = tm_e & ~((nidx_e <= TRAILER_LAST) && (b != trailer_char(nidx_e[3:0])));

        offset_next    = cur + 32'd1;
        phase_next     = ph_e;
        hidx_next      = hidx_e;
        size_next      = size_e;
        nsize_next     = nsize_e;
        nidx_next      = nidx_e;
        tmatch_next    = tm_e;
        skip_next      = skip_e;
        size_pad_next  = size_pad_reg;
        name_last_next = name_last_reg;
        produce        = 1'b0;
        res            = '0;

        unique case (ph_e)
            PH_HEADER:
            begin
                if (hidx_e < MAGIC_LEN && b != magic_char(hidx_e[2:0]))
                begin
                    produce         = 1'b1;
                    res.record_kind = KIND_BADMAG;
                    phase_next      = PH_DONE;
                end
                else
                begin
                    if (hidx_e >= FSIZE_FIRST && hidx_e <= FSIZE_LAST)
                    begin
                        size_next = acc_size;
                        if (hidx_e == FSIZE_LAST)
                            size_pad_next = (acc_size + 32'd3) & ~32'd3;
                    end
                    if (hidx_e >= NSIZE_FIRST && hidx_e <= NSIZE_LAST)
                    begin
                        nsize_next = acc_nsize;
                        if (hidx_e == NSIZE_LAST)
                            name_last_next = (acc_nsize == 32'd0) ? 32'd0
                                                                  : acc_nsize - 32'd1;
                    end
                    if (hidx_e >= HDR_LAST)
                    begin
                        phase_next  = PH_NAME;
                        nidx_next   = 32'd0;
                        tmatch_next = 1'b1;
                        hidx_next   = 7'd0;
                    end
                    else
                    begin
                        hidx_next = hidx_e + 7'd1;
                    end
                end
            end
            PH_NAME:
            begin
                produce     = 1'b1;
                tmatch_next = tm_new;
                if (nidx_e < name_last_reg)
                begin
                    res.name_byte      = b;
                    res.name_byte_kept = (nidx_e < 32'(NAME_KEEP_LIMIT));
                    res.record_kind    = KIND_NAME;
                    nidx_next          = nidx_e + 32'd1;
                end
                else if (tm_new && nidx_e >= TRAILER_LAST)
                begin
                    res.record_kind = KIND_TRAILER;
                    phase_next      = PH_DONE;
                end
                else
                begin
                    res.name_byte      = b;
                    res.name_byte_kept = (nidx_e < 32'(NAME_KEEP_LIMIT));
                    res.record_kind    = KIND_FILE;
                    res.data_offset    = {cur[31:2] + 30'd1, 2'b00};
                    res.file_size      = size_e;
                    res.name_size      = nsize_e;
                    phase_next  = (skip_calc != 32'd0) ? PH_SKIP : PH_HEADER;
                    hidx_next   = 7'd0;
                    size_next   = 32'd0;
                    nsize_next  = 32'd0;
                    nidx_next   = 32'd0;
                    tmatch_next = 1'b1;
                    skip_next   = skip_calc;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0)
                    phase_next = PH_HEADER;
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            offset_reg <= '0;
            hidx_reg   <= '0;
            size_reg   <= '0;
            nsize_reg  <= '0;
            nidx_reg   <= '0;
            tmatch_reg <= 1'b1;
            skip_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            hidx_reg   <= hidx_next;
            size_reg   <= size_next;
            nsize_reg  <= nsize_next;
            nidx_reg   <= nidx_next;
            tmatch_reg <= tmatch_next;
            skip_reg   <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            size_pad_reg  <= size_pad_next;
            name_last_reg <= name_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rec_valid_reg <= 1'b0;
        else if (accept && produce)
            rec_valid_reg <= 1'b1;
        else if (!rec_stall)
            rec_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && produce)
            rec_item_reg <= res;
    end

endmodule

@@ src/cnap_checker.sv @@
// cnap_checker: port-level assertions for the cpio newc archive parser.
// Depends on cnap_pkg; bound to cpio_newc_archive_parser_top below.
module cnap_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                arc_valid,
    input logic                arc_stall,
    input cnap_pkg::arc_item_t arc_item,
    input logic                rec_valid,
    input logic                rec_stall,
    input cnap_pkg::rec_item_t rec_item
);
    import cnap_pkg::*;

    // input side only waits on a held, stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        arc_stall |-> (rec_valid && rec_stall))
        else $error("arc_stall without a stalled result");

    a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec_stall) |=> (rec_valid && $stable(rec_item)))
        else $error("stalled result transaction changed");

    a_nonfile_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec_item.record_kind != KIND_FILE) |->
        (rec_item.data_offset == 32'd0 && rec_item.file_size == 32'd0
         && rec_item.name_size == 32'd0))
        else $error("record fields set outside a file record");

    a_end_no_name: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && (rec_item.record_kind == KIND_TRAILER
                       || rec_item.record_kind == KIND_BADMAG)) |->
        (rec_item.name_byte == 8'd0 && !rec_item.name_byte_kept))
        else $error("end record carries a name byte");

    a_data_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec_item.record_kind == KIND_FILE) |->
        (rec_item.data_offset[1:0] == 2'b00))
        else $error("file data offset not 4-aligned");

endmodule

bind cpio_newc_archive_parser_top cnap_checker u_cnap_checker (.*);
